// ===== design/hmi_pkg.sv =====
// ----------------------------------------------------------------------------
// hmi_pkg
// Shared types and constants for the histogram median interpolation unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hmi_pkg;

	localparam int MAX_BINS_DEF    = 256;
	localparam int COUNT_WIDTH_DEF = 16;

	localparam int BIN_FIELD_W = 16;
	localparam int CFG_W       = 9;
	localparam int MED_W       = 17;
	localparam int QUO_W       = 18;
	localparam int DIV_STEPS   = 18;
	localparam int STEP_W      = 5;

	localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;
	localparam logic [MED_W-1:0] FRAC_ONE  = 17'h10000;

	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EMPTY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_READ,
		ST_CHECK,
		ST_MUL,
		ST_SETUP,
		ST_DIV,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic walk_init;
		logic step;
		logic mul;
		logic setup;
		logic div_step;
		logic fin_empty;
		logic fin_end;
		logic fin_div;
	} cmd_t;

	typedef struct packed {
		logic frame_end;
		logic empty;
		logic hit;
		logic last;
		logic div_last;
	} sts_t;

endpackage

`default_nettype wire

// ===== design/hmi_ctrl.sv =====
// ----------------------------------------------------------------------------
// hmi_ctrl
// Sequencer for load, bin walk, interpolation setup and division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hmi_ctrl
	import hmi_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  sts_t      sts,
	output cmd_t      cmd
);

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start && sts.frame_end) begin
					state_next = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_next = sts.empty ? ST_IDLE : ST_READ;
			end
			ST_READ: begin
				state_next = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.hit) begin
					state_next = ST_MUL;
				end else if (sts.last) begin
					state_next = ST_IDLE;
				end else begin
					state_next = ST_READ;
				end
			end
			ST_MUL: begin
				state_next = ST_SETUP;
			end
			ST_SETUP: begin
				state_next = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_last) begin
					state_next = ST_FIN;
				end
			end
			ST_FIN: begin
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_EVAL: begin
				cmd.fin_empty = sts.empty;
				cmd.walk_init = !sts.empty;
			end
			ST_READ: begin
			end
			ST_CHECK: begin
				cmd.fin_end = !sts.hit && sts.last;
				cmd.step    = !sts.hit && !sts.last;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
			end
			ST_FIN: begin
				cmd.fin_div = 1'b1;
			end
			default: begin
				cmd  = '0;
				busy = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/hmi_datapath.sv =====
// ----------------------------------------------------------------------------
// hmi_datapath
// Bin memory, totals, walk registers, multipliers and restoring divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hmi_datapath
	import hmi_pkg::*;
#(
	parameter int MAX_BINS    = MAX_BINS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  cmd_t                        cmd,
	output sts_t                        sts,
	input  wire logic [BIN_FIELD_W-1:0] bin_count,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_W-1:0]       cfg_data,
	output logic                        done,
	output logic [MED_W-1:0]            median_level,
	output logic                        status
);

	localparam int CW = COUNT_WIDTH;
	localparam int AW = $clog2(MAX_BINS);
	localparam int LW = $clog2(MAX_BINS + 1);
	localparam int TW = CW + AW;
	localparam int SW = TW + 2;
	localparam int PW = CW + AW;
	localparam int RW = CW + AW + 2;
	localparam int DW = RW - 1;

	logic [CW-1:0] mem [MAX_BINS];

	logic [CFG_W-1:0] bins_in_use_q;
	logic [AW-1:0]    load_cnt_q;
	logic [TW-1:0]    total_q;
	logic [TW-1:0]    cum_q;
	logic [AW-1:0]    walk_idx_q;
	logic [CW-1:0]    rdata_q;
	logic [PW-1:0]    prod_k_q;
	logic [PW-1:0]    prod_n_q;
	logic [RW-1:0]    rem_q;
	logic [DW-1:0]    div_q;
	logic [QUO_W-1:0] quo_q;
	logic [STEP_W-1:0] cnt_q;
	logic             done_q;
	logic [MED_W-1:0] median_q;
	logic             status_q;

	logic [CW-1:0] b_in;
	logic [LW-1:0] n;
	logic [SW-1:0] twice_sum;
	logic [RW-1:0] shifted;
	logic [RW-1:0] cmp;
	logic          ge;
	logic [RW-1:0] x_num;

	assign b_in = CW'(bin_count);

	always_comb begin
		if (32'(bins_in_use_q) > 32'(MAX_BINS)) begin
			n = LW'(MAX_BINS);
		end else begin
			n = LW'(bins_in_use_q);
		end
	end

	assign twice_sum = (SW'(cum_q) + SW'(rdata_q)) << 1;

	assign sts.frame_end = (LW'(load_cnt_q) + LW'(1)) >= n;
	assign sts.empty     = (n <= LW'(1)) || (total_q == '0);
	assign sts.hit       = twice_sum >= SW'(total_q);
	assign sts.last      = LW'(walk_idx_q) == (n - LW'(1));
	assign sts.div_last  = cnt_q == STEP_W'(DIV_STEPS - 1);

	// integer bits first, then one fraction bit per step
	assign shifted = (cnt_q >= STEP_W'(2)) ? {rem_q[RW-2:0], 1'b0} : rem_q;
	assign cmp     = (cnt_q == '0) ? {div_q, 1'b0} : {1'b0, div_q};
	assign ge      = shifted >= cmp;

	assign x_num = RW'({prod_k_q, 1'b0}) + RW'(total_q) - RW'({cum_q, 1'b0});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mem[load_cnt_q] <= b_in;
		end
		rdata_q <= mem[walk_idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_in_use_q <= CFG_RESET;
			load_cnt_q    <= '0;
			total_q       <= '0;
			cum_q         <= '0;
			walk_idx_q    <= '0;
			cnt_q         <= '0;
			done_q        <= 1'b0;
		end else begin
			done_q <= cmd.fin_empty || cmd.fin_end || cmd.fin_div;
			if (cfg_we) begin
				bins_in_use_q <= cfg_data;
			end
			if (cmd.load) begin
				total_q <= total_q + TW'(b_in);
				if (sts.frame_end) begin
					load_cnt_q <= '0;
				end else begin
					load_cnt_q <= load_cnt_q + AW'(1);
				end
			end
			if (cmd.fin_empty || cmd.fin_end || cmd.fin_div) begin
				total_q <= '0;
			end
			if (cmd.walk_init) begin
				cum_q      <= '0;
				walk_idx_q <= '0;
			end
			if (cmd.step) begin
				cum_q      <= cum_q + TW'(rdata_q);
				walk_idx_q <= walk_idx_q + AW'(1);
			end
			if (cmd.setup) begin
				cnt_q <= '0;
			end
			if (cmd.div_step) begin
				cnt_q <= cnt_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_k_q <= PW'(rdata_q) * PW'(walk_idx_q);
			prod_n_q <= PW'(rdata_q) * PW'(n - LW'(1));
		end
		if (cmd.setup) begin
			rem_q <= x_num;
			div_q <= DW'({prod_n_q, 1'b0});
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? (shifted - cmp) : shifted;
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
		if (cmd.fin_empty) begin
			median_q <= '0;
			status_q <= STATUS_EMPTY;
		end
		if (cmd.fin_end) begin
			median_q <= FRAC_ONE;
			status_q <= STATUS_OK;
		end
		if (cmd.fin_div) begin
			median_q <= (quo_q > QUO_W'(FRAC_ONE)) ? FRAC_ONE : MED_W'(quo_q);
			status_q <= STATUS_OK;
		end
	end

	assign done         = done_q;
	assign median_level = median_q;
	assign status       = status_q;

endmodule

`default_nettype wire

// ===== design/histogram_median_interp_unit.sv =====
// ----------------------------------------------------------------------------
// histogram_median_interp_unit
// Median of a luminance histogram, interpolated within its bin, Q1.16 out.
// ----------------------------------------------------------------------------
// A request on start (taken when busy is low) carries one bin count; bins of
// a frame arrive lowest first, one per cycle while busy is low. bins_in_use
// sets the frame length; the user must write it over the cfg_valid/cfg_ready
// channel while idle, and the block itself does not enforce this. The final
// bin starts a walk over the bin memory, with a registered memory read and a
// compare for each bin visited; once the median bin is found, a multiply, a
// setup and a restoring divider with an 18-bit quotient follow. An empty
// frame is reported without a walk. busy is high from the final bin until
// the result is out.
// done marks median_level and status for exactly one cycle; the receiver
// cannot hold it off. Reset clears counters, totals and sets bins_in_use to
// 256; bin memory contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module histogram_median_interp_unit
	import hmi_pkg::*;
#(
	parameter int MAX_BINS    = MAX_BINS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic [BIN_FIELD_W-1:0] bin_count,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_W-1:0]       cfg_data,
	output logic                        done,
	output logic [MED_W-1:0]            median_level,
	output logic                        status
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	hmi_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	hmi_datapath #(
		.MAX_BINS    (MAX_BINS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.bin_count    (bin_count),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_data     (cfg_data),
		.done         (done),
		.median_level (median_level),
		.status       (status)
	);

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_accept_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result right after a request");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_EMPTY) |-> median_level == '0)
		else $error("empty result with nonzero median");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> median_level <= FRAC_ONE)
		else $error("median above one");

endmodule

`default_nettype wire

// ===== sim/tb_histogram_median_interp_unit.sv =====
// ----------------------------------------------------------------------------
// tb_histogram_median_interp_unit
// Self-checking bench for the histogram median interpolation unit.
// ----------------------------------------------------------------------------
// Loads histogram frames one bin per request and predicts the interpolated
// Q1.16 median and the empty status of each completed frame. A short directed
// part covers empty, all-zero, saturated and mid-frame length changes. Then
// random frames follow with mixed count shapes, random sender gaps and
// bins_in_use changes while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_histogram_median_interp_unit;

	import hmi_pkg::*;

	localparam int unsigned RANDOM_BINS = 1400;
	localparam int unsigned CALM_AFTER  = 1150;
	localparam int unsigned SETTLE      = 4;
	localparam int unsigned DRAIN_END   = 600;
	localparam int unsigned LIMIT       = 4000000;

	typedef struct packed {
		logic [MED_W-1:0] level;
		logic             st;
	} median_result_t;

	typedef enum int unsigned {
		SHAPE_WIDE,
		SHAPE_LOW,
		SHAPE_SPARSE,
		SHAPE_RAIL,
		SHAPE_FLAT
	} count_shape_t;

	class hist_median_board;
		logic [BIN_FIELD_W-1:0] bin_mem [MAX_BINS_DEF];
		int unsigned            load_count;
		longint unsigned        total;
		int unsigned            frame_len;
		median_result_t         median_due [$];
		int unsigned            faults;

		function new();
			load_count = 0;
			total      = 0;
			frame_len  = 32'(CFG_RESET);
			faults     = 0;
		endfunction

		function void set_frame_len(logic [CFG_W-1:0] v);
			frame_len = 32'(v);
		endfunction

		function int unsigned pending();
			return median_due.size();
		endfunction

		function median_result_t walk_median(int unsigned n);
			longint unsigned cum;
			longint unsigned b;
			longint unsigned num;
			longint unsigned den;
			int unsigned     k;
			median_result_t  r;
			r.level = '0;
			r.st    = STATUS_EMPTY;
			if (n <= 1 || total == 0) begin
				return r;
			end
			r.st    = STATUS_OK;
			r.level = FRAC_ONE;
			cum     = 0;
			for (k = 0; k < n; k++) begin
				b = bin_mem[k];
				if (2 * (cum + b) >= total) begin
					if (b == 0) begin
						num = longint'(k) * FRAC_ONE;
						den = n - 1;
					end else begin
						num = (2 * b * k + total - 2 * cum) * FRAC_ONE;
						den = 2 * b * (n - 1);
					end
					num = num / den;
					r.level = (num > FRAC_ONE) ? FRAC_ONE : num[MED_W-1:0];
					return r;
				end
				cum += b;
			end
			return r;
		endfunction

		function void take_bin(logic [BIN_FIELD_W-1:0] v);
			int unsigned n;
			n = (frame_len > MAX_BINS_DEF) ? MAX_BINS_DEF : frame_len;
			if (load_count < MAX_BINS_DEF) begin
				bin_mem[load_count] = v;
			end
			total += v;
			if (load_count + 1 < n) begin
				load_count++;
				return;
			end
			median_due.insert(median_due.size(), walk_median(n));
			load_count = 0;
			total      = 0;
		endfunction

		function void check_median(logic [MED_W-1:0] level, logic st);
			median_result_t want;
			if (median_due.size() == 0) begin
				faults++;
				$error("unexpected result: median_level %0d status %0d", level, st);
				return;
			end
			want = median_due.pop_front();
			if (level !== want.level) begin
				faults++;
				$error("median_level expected %0d actual %0d", want.level, level);
			end
			if (st !== want.st) begin
				faults++;
				$error("status expected %0d actual %0d", want.st, st);
			end
		endfunction
	endclass

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   start     = 1'b0;
	logic [BIN_FIELD_W-1:0] bin_count = '0;
	logic                   cfg_valid = 1'b0;
	logic [CFG_W-1:0]       cfg_data  = '0;
	logic                   busy;
	logic                   cfg_ready;
	logic                   done;
	logic [MED_W-1:0]       median_level;
	logic                   status;

	hist_median_board sb = new();
	int unsigned      cycles = 0;

	histogram_median_interp_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.bin_count   (bin_count),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.done        (done),
		.median_level(median_level),
		.status      (status)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_histogram_median_interp_unit: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_median(median_level, status);
		end
	end

	task automatic send_bin(input logic [BIN_FIELD_W-1:0] v);
		@(negedge clk);
		start     <= 1'b1;
		bin_count <= v;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.take_bin(v);
	endtask

	task automatic pause(input int unsigned n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain(input int unsigned settle);
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_bins_in_use(input logic [CFG_W-1:0] v);
		drain(SETTLE);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_frame_len(v);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [BIN_FIELD_W-1:0] draw_count(count_shape_t shape);
		logic [BIN_FIELD_W-1:0] v;
		v = BIN_FIELD_W'($urandom);
		case (shape)
			SHAPE_WIDE: begin
				return v;
			end
			SHAPE_LOW: begin
				return BIN_FIELD_W'($urandom_range(0, 15));
			end
			SHAPE_SPARSE: begin
				return ($urandom_range(0, 3) == 0) ? v : '0;
			end
			SHAPE_RAIL: begin
				return ($urandom_range(0, 1) == 0) ? '1 : '0;
			end
			default: begin
				return '0;
			end
		endcase
	endfunction

	initial begin : stimulus
		int unsigned      sent;
		int unsigned      n_items;
		int unsigned      frames;
		int unsigned      partial;
		int unsigned      remain;
		int unsigned      eff;
		int unsigned      big_left;
		int unsigned      pick;
		logic [CFG_W-1:0] cfg;
		logic             gappy;
		logic             big;
		count_shape_t     shape;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// two-bin frames: all zero, full scale, median in first and last bin
		write_bins_in_use(9'd2);
		send_bin('0);
		send_bin('0);
		send_bin('1);
		send_bin('1);
		send_bin('1);
		send_bin('0);
		send_bin('0);
		send_bin('1);
		// too few bins
		write_bins_in_use(9'd1);
		send_bin(16'h0005);
		send_bin('0);
		write_bins_in_use(9'd0);
		send_bin('1);
		write_bins_in_use(9'd4);
		send_bin(16'hAAAA);
		send_bin(16'h5555);
		send_bin(16'h5555);
		send_bin(16'hAAAA);
		// shrink mid-frame so the walk runs off the end
		write_bins_in_use(9'd8);
		send_bin(16'd1);
		send_bin(16'd1);
		send_bin(16'd1);
		send_bin(16'd1000);
		send_bin(16'd1000);
		write_bins_in_use(9'd3);
		send_bin(16'd1000);
		// grow mid-frame
		write_bins_in_use(9'd3);
		send_bin(16'd7);
		write_bins_in_use(9'd5);
		send_bin(16'd300);
		send_bin(16'd2);
		send_bin(16'd9);
		send_bin(16'd40);

		sent     = 0;
		big_left = 1;
		while (sent < RANDOM_BINS) begin
			pick = $urandom_range(0, 99);
			big  = 1'b0;
			if (sent == 0) begin
				cfg = 9'd256;
				big = 1'b1;
			end else if (big_left != 0 && sent < 900 && pick < 3) begin
				cfg = CFG_W'($urandom_range(257, 511));
				big = 1'b1;
				big_left--;
			end else if (pick < 8) begin
				cfg = CFG_W'($urandom_range(0, 1));
			end else if (pick < 22) begin
				cfg = CFG_W'($urandom_range(25, 64));
			end else begin
				cfg = CFG_W'($urandom_range(2, 24));
			end
			write_bins_in_use(cfg);

			eff    = (cfg > MAX_BINS_DEF) ? MAX_BINS_DEF : cfg;
			frames = big ? 1 : $urandom_range(1, 4);
			remain = (sb.load_count + 1 >= eff) ? 1 : eff - sb.load_count;
			partial = 0;
			if (!big && eff >= 3 && $urandom_range(0, 5) == 0) begin
				partial = $urandom_range(1, eff - 2);
			end
			n_items = remain + (frames - 1) * ((eff <= 1) ? 1 : eff) + partial;

			shape = count_shape_t'($urandom_range(0, 4));
			if (shape == SHAPE_FLAT && $urandom_range(0, 1) == 0) begin
				shape = SHAPE_WIDE;
			end
			gappy = (sent < CALM_AFTER) && ($urandom_range(0, 2) != 0);

			repeat (n_items) begin
				if (gappy && $urandom_range(0, 2) == 0) begin
					pause($urandom_range(1, 8));
				end
				send_bin(draw_count(shape));
				sent++;
			end
		end

		drain(DRAIN_END);
		if (sb.faults == 0 && sb.pending() == 0) begin
			$display("tb_histogram_median_interp_unit: clean");
		end else begin
			$display("tb_histogram_median_interp_unit: errors");
		end
		$finish;
	end

endmodule
